### rtl/cfrrn_pkg.sv
// ----------------------------------------------------------------------------
// cfrrn_pkg
// shared types and constants for the cubic fit relative residual norm unit
// ----------------------------------------------------------------------------
package cfrrn_pkg;

    localparam int unsigned DataW        = 32;
    localparam int unsigned FracBitsDef  = 16;
    localparam int unsigned CfgIdxW      = 2;

    localparam logic [CfgIdxW-1:0] REG_COEF_CONST  = 2'd0;
    localparam logic [CfgIdxW-1:0] REG_COEF_LINEAR = 2'd1;
    localparam logic [CfgIdxW-1:0] REG_COEF_SQUARE = 2'd2;
    localparam logic [CfgIdxW-1:0] REG_COEF_CUBE   = 2'd3;

    typedef struct packed {
        logic signed [DataW-1:0] indep_value;
        logic signed [DataW-1:0] observed_value;
        logic                    last_sample;
    } in_word_t;

    typedef struct packed {
        logic signed [DataW-1:0] expected_value;
        logic signed [DataW-1:0] difference;
        logic                    zero_divisor;
        logic [DataW-1:0]        residual_norm;
        logic                    norm_valid;
    } out_word_t;

endpackage

### rtl/cfrrn_mul.sv
// ----------------------------------------------------------------------------
// cfrrn_mul
// bit-serial signed multiplier, one multiplier bit per cycle
// ----------------------------------------------------------------------------
module cfrrn_mul import cfrrn_pkg::*; (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic signed [DataW-1:0]   op_a,
    input  logic signed [DataW-1:0]   op_b,
    output logic                      done,
    output logic signed [2*DataW-1:0] product
);
    localparam int unsigned CntW = $clog2(DataW + 1);

    logic                      busy_reg, busy_next;
    logic [CntW-1:0]           cnt_reg, cnt_next;
    logic signed [DataW:0]     hi_reg, hi_next;
    logic [DataW-1:0]          lo_reg, lo_next;
    logic signed [DataW-1:0]   a_reg, a_next;
    logic                      done_reg, done_next;
    logic signed [DataW:0]     addend;
    logic signed [DataW:0]     sum;

    // shift-add on the low multiplier bit; top bit has negative weight
    always_comb begin
        addend = '0;
        if (lo_reg[0]) begin
            addend = (cnt_reg == CntW'(DataW - 1)) ? -{a_reg[DataW-1], a_reg}
                                                   : {a_reg[DataW-1], a_reg};
        end
        sum       = hi_reg + addend;
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        hi_next   = hi_reg;
        lo_next   = lo_reg;
        a_next    = a_reg;
        done_next = 1'b0;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            hi_next   = '0;
            lo_next   = op_b;
            a_next    = op_a;
        end else if (busy_reg) begin
            hi_next  = sum >>> 1;
            lo_next  = {sum[0], lo_reg[DataW-1:1]};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CntW'(DataW - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        hi_reg <= hi_next;
        lo_reg <= lo_next;
        a_reg  <= a_next;
    end

    assign done    = done_reg;
    assign product = {hi_reg[DataW-1:0], lo_reg};
endmodule

### rtl/cfrrn_div.sv
// ----------------------------------------------------------------------------
// cfrrn_div
// restoring divider, one quotient bit per cycle, truncates toward zero
// ----------------------------------------------------------------------------
module cfrrn_div import cfrrn_pkg::*; #(
    parameter int unsigned NumW = 48
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [NumW-1:0]       num_mag,
    input  logic [DataW-1:0]      den_mag,
    output logic                  done,
    output logic [NumW-1:0]       quot_mag
);
    localparam int unsigned CntW = $clog2(NumW + 1);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [CntW-1:0]       cnt_reg, cnt_next;
    logic [DataW:0]        rem_reg, rem_next;
    logic [NumW-1:0]       q_reg, q_next;
    logic [DataW-1:0]      d_reg, d_next;
    logic [DataW:0]        trial;
    logic [DataW:0]        diff;

    always_comb begin
        trial     = {rem_reg[DataW-1:0], q_reg[NumW-1]};
        diff      = trial - {1'b0, d_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        d_next    = d_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            q_next    = num_mag;
            d_next    = den_mag;
        end else if (busy_reg) begin
            if (!diff[DataW]) begin
                rem_next = diff;
                q_next   = {q_reg[NumW-2:0], 1'b1};
            end else begin
                rem_next = trial;
                q_next   = {q_reg[NumW-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CntW'(NumW - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        q_reg   <= q_next;
        d_reg   <= d_next;
    end

    assign done     = done_reg;
    assign quot_mag = q_reg;
endmodule

### rtl/cfrrn_sqrt.sv
// ----------------------------------------------------------------------------
// cfrrn_sqrt
// digit-by-digit integer square root, one result bit per cycle
// ----------------------------------------------------------------------------
module cfrrn_sqrt import cfrrn_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [63:0]      radicand,
    output logic             done,
    output logic [31:0]      root
);
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [4:0]       cnt_reg, cnt_next;
    logic [63:0]      x_reg, x_next;
    logic [33:0]      rem_reg, rem_next;
    logic [31:0]      r_reg, r_next;
    logic [33:0]      trial;
    logic [33:0]      sub;

    always_comb begin
        trial     = {rem_reg[31:0], x_reg[63:62]};
        sub       = trial - {r_reg, 2'b01};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        x_next    = x_reg;
        rem_next  = rem_reg;
        r_next    = r_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            x_next    = radicand;
            rem_next  = '0;
            r_next    = '0;
        end else if (busy_reg) begin
            x_next = {x_reg[61:0], 2'b00};
            if (!sub[33]) begin
                rem_next = sub;
                r_next   = {r_reg[30:0], 1'b1};
            end else begin
                rem_next = trial;
                r_next   = {r_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == 5'd31) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        x_reg   <= x_next;
        rem_reg <= rem_next;
        r_reg   <= r_next;
    end

    assign done = done_reg;
    assign root = r_reg;
endmodule

### rtl/cubic_fit_relative_residual_norm_unit.sv
// ----------------------------------------------------------------------------
// cubic_fit_relative_residual_norm_unit
// cubic model evaluation with running relative root-sum-square residual
// ----------------------------------------------------------------------------
// One word in gives one word out. The model is evaluated by Horner's rule
// through a bit-serial 32x32 multiplier (three products), the relative
// error by a 48-bit restoring divider and the square of the quotient again
// through the multiplier. On a word marked last the 32-bit square root runs
// as well. When the model value is zero the divide and square are skipped.
// One word at a time is in work; the next is taken once the result is in
// the output register, while that result may still wait for m_ready.
module cubic_fit_relative_residual_norm_unit import cfrrn_pkg::*; #(
    parameter int unsigned FRACTION_BITS = FracBitsDef
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [CfgIdxW-1:0]   cfg_index,
    input  logic [DataW-1:0]     cfg_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  in_word_t             s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output out_word_t            m_data
);
    localparam int unsigned NumW = DataW + FRACTION_BITS;

    // sequencer codes
    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_H1    = 4'd1;
    localparam logic [3:0] ST_H2    = 4'd2;
    localparam logic [3:0] ST_H3    = 4'd3;
    localparam logic [3:0] ST_DIFF  = 4'd4;
    localparam logic [3:0] ST_DIV   = 4'd5;
    localparam logic [3:0] ST_SQ    = 4'd6;
    localparam logic [3:0] ST_ACC   = 4'd7;
    localparam logic [3:0] ST_SQRT  = 4'd8;
    localparam logic [3:0] ST_OUT   = 4'd9;

    localparam logic signed [DataW-1:0] S_MAX = {1'b0, {(DataW-1){1'b1}}};
    localparam logic signed [DataW-1:0] S_MIN = {1'b1, {(DataW-1){1'b0}}};
    // product clamp, wide enough that any coefficient still saturates the sum
    localparam logic signed [DataW+1:0] P_MAX = {2'b00, {DataW{1'b1}}};
    localparam logic signed [DataW+1:0] P_MIN = {2'b11, {DataW{1'b0}}};

    // coefficient registers
    logic signed [DataW-1:0] c0_reg, c1_reg, c2_reg, c3_reg;

    logic [3:0]              state_reg, state_next;
    logic                    started_reg, started_next;
    logic signed [DataW-1:0] t_reg, obs_reg, acc_reg, diff_reg;
    logic                    last_reg, zero_reg, neg_reg;
    logic [63:0]             sum_reg;
    logic [DataW-1:0]        norm_reg;
    logic                    m_valid_reg;
    out_word_t               out_reg;
    logic                    out_load;

    logic                    mul_start, mul_done;
    logic signed [DataW-1:0] mul_a, mul_b;
    logic signed [2*DataW-1:0] mul_p;
    logic                    div_start, div_done;
    logic [NumW-1:0]         div_num, div_q;
    logic [DataW-1:0]        div_den;
    logic                    sqrt_start, sqrt_done;
    logic [63:0]             sqrt_x;
    logic [DataW-1:0]        sqrt_r;

    logic signed [2*DataW-1:0] prod_sh;
    logic signed [DataW+1:0]   hsum;
    logic signed [DataW+1:0]   hsat;
    logic signed [DataW-1:0]   hadd;
    logic signed [DataW:0]     dwide;
    logic [DataW-1:0]          diff_mag;
    logic signed [DataW:0]     qsigned;
    logic signed [DataW-1:0]   qsat;
    logic [63:0]               sq_term;
    logic [64:0]               sum_add;

    cfrrn_mul u_mul (
        .aclk(aclk), .aresetn(aresetn), .start(mul_start),
        .op_a(mul_a), .op_b(mul_b), .done(mul_done), .product(mul_p)
    );

    cfrrn_div #(.NumW(NumW)) u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start),
        .num_mag(div_num), .den_mag(div_den), .done(div_done), .quot_mag(div_q)
    );

    cfrrn_sqrt u_sqrt (
        .aclk(aclk), .aresetn(aresetn), .start(sqrt_start),
        .radicand(sqrt_x), .done(sqrt_done), .root(sqrt_r)
    );

    assign s_ready  = (state_reg == ST_IDLE);
    // the output register takes a new word when empty or read this cycle
    assign out_load = (state_reg == ST_OUT) && (!m_valid_reg || m_ready);

    // horner step: floor shift of product plus coefficient, saturated
    always_comb begin
        prod_sh = mul_p >>> FRACTION_BITS;
        unique case (state_reg)
            ST_H1:   hadd = c2_reg;
            ST_H2:   hadd = c1_reg;
            default: hadd = c0_reg;
        endcase
        // the shifted product may exceed 34 bits; past +-2^32 the sum saturates anyway
        if (prod_sh > 64'(P_MAX)) begin
            hsat = P_MAX;
        end else if (prod_sh < 64'(P_MIN)) begin
            hsat = P_MIN;
        end else begin
            hsat = prod_sh[DataW+1:0];
        end
        hsum = hsat + (DataW+2)'(hadd);
        dwide = (DataW+1)'(acc_reg) - (DataW+1)'(obs_reg);
    end

    logic signed [DataW-1:0] hres;
    always_comb begin
        // clamp of a product already past the range keeps the sign of the true sum
        if (hsum > (DataW+2)'(S_MAX)) begin
            hres = S_MAX;
        end else if (hsum < (DataW+2)'(S_MIN)) begin
            hres = S_MIN;
        end else begin
            hres = hsum[DataW-1:0];
        end
    end

    always_comb begin
        diff_mag = diff_reg[DataW-1] ? DataW'(-diff_reg) : diff_reg;
        div_num  = NumW'(diff_mag) << FRACTION_BITS;
        div_den  = acc_reg[DataW-1] ? DataW'(-acc_reg) : acc_reg;
        qsigned  = neg_reg ? -(DataW+1)'(div_q) : (DataW+1)'(div_q);
        if (div_q > NumW'(S_MAX) + NumW'(neg_reg)) begin
            qsat = neg_reg ? S_MIN : S_MAX;
        end else begin
            qsat = qsigned[DataW-1:0];
        end
        sq_term = 64'(mul_p) >> FRACTION_BITS;
        sum_add = {1'b0, sum_reg} + {1'b0, sq_term};
        sqrt_x  = sum_reg << FRACTION_BITS;
    end

    always_comb begin
        state_next   = state_reg;
        started_next = 1'b0;
        mul_start    = 1'b0;
        div_start    = 1'b0;
        sqrt_start   = 1'b0;
        mul_a        = acc_reg;
        mul_b        = t_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_ready) begin
                    state_next   = ST_H1;
                    started_next = 1'b1;
                end
            end
            ST_H1, ST_H2, ST_H3: begin
                mul_start = started_reg;
                if (mul_done) begin
                    state_next   = (state_reg == ST_H3) ? ST_DIFF : state_reg + 4'd1;
                    started_next = 1'b1;
                end
            end
            ST_DIFF: begin
                state_next   = ST_DIV;
                started_next = 1'b1;
            end
            ST_DIV: begin
                div_start = started_reg && !zero_reg;
                if (zero_reg) begin
                    state_next = ST_ACC;
                end else if (div_done) begin
                    state_next   = ST_SQ;
                    started_next = 1'b1;
                end
            end
            ST_SQ: begin
                mul_a     = diff_reg;
                mul_b     = diff_reg;
                mul_start = started_reg;
                if (mul_done) begin
                    state_next = ST_ACC;
                end
            end
            ST_ACC: begin
                state_next   = last_reg ? ST_SQRT : ST_OUT;
                started_next = 1'b1;
            end
            ST_SQRT: begin
                sqrt_start = started_reg;
                if (sqrt_done || (sum_reg >> (64 - FRACTION_BITS)) != 64'd0) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            started_reg <= 1'b0;
            m_valid_reg <= 1'b0;
            sum_reg     <= '0;
            c0_reg      <= '0;
            c1_reg      <= '0;
            c2_reg      <= '0;
            c3_reg      <= '0;
        end else begin
            state_reg   <= state_next;
            started_reg <= started_next;
            if (cfg_we) begin
                unique case (cfg_index)
                    REG_COEF_CONST:  c0_reg <= cfg_data;
                    REG_COEF_LINEAR: c1_reg <= cfg_data;
                    REG_COEF_SQUARE: c2_reg <= cfg_data;
                    REG_COEF_CUBE:   c3_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (state_reg == ST_ACC && !zero_reg) begin
                sum_reg <= sum_add[64] ? '1 : sum_add[63:0];
            end
            if (state_reg == ST_OUT && last_reg) begin
                sum_reg <= '0;
            end
        end
        // datapath
        if (state_reg == ST_IDLE && s_valid && s_ready) begin
            t_reg    <= s_data.indep_value;
            obs_reg  <= s_data.observed_value;
            last_reg <= s_data.last_sample;
            acc_reg  <= c3_reg;
            norm_reg <= '0;
        end
        if ((state_reg == ST_H1 || state_reg == ST_H2 || state_reg == ST_H3) && mul_done) begin
            acc_reg <= hres;
        end
        if (state_reg == ST_DIFF) begin
            diff_reg <= (dwide > (DataW+1)'(S_MAX)) ? S_MAX :
                        (dwide < (DataW+1)'(S_MIN)) ? S_MIN : dwide[DataW-1:0];
            zero_reg <= (acc_reg == '0);
            neg_reg  <= acc_reg[DataW-1] ^ dwide[DataW];
        end
        if (state_reg == ST_DIV && div_done) begin
            // the quotient reuses the difference register
            diff_reg <= qsat;
        end
        if (state_reg == ST_ACC) begin
            // restore the reported difference
            diff_reg <= (dwide > (DataW+1)'(S_MAX)) ? S_MAX :
                        (dwide < (DataW+1)'(S_MIN)) ? S_MIN : dwide[DataW-1:0];
        end
        if (state_reg == ST_SQRT) begin
            norm_reg <= ((sum_reg >> (64 - FRACTION_BITS)) != 64'd0) ? '1 : sqrt_r;
        end
        if (out_load) begin
            out_reg.expected_value <= acc_reg;
            out_reg.difference     <= diff_reg;
            out_reg.zero_divisor   <= zero_reg;
            out_reg.residual_norm  <= norm_reg;
            out_reg.norm_valid     <= last_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    // a new word is never taken while the sequencer is busy
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> !s_ready)
        else $error("input taken during work");

    // the output register fills only from the final sequencer step
    a_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg == ST_OUT))
        else $error("result without completed work");

    // the sum is cleared after a set result
    a_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OUT && last_reg) |=> (sum_reg == 64'd0))
        else $error("sum not cleared after last word");
endmodule
